FILE: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, codes and the column span helper of the bitmap shape
// rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

	localparam int CANVAS_ROWS_DEF = 32;
	localparam int CANVAS_COLS_DEF = 64;
	localparam int ROW_ADDR_W      = 6;
	localparam int ROW_BITS_W      = 64;

	typedef enum logic [2:0] {
		CMD_FILL   = 3'd0,
		CMD_LINE   = 3'd1,
		CMD_TRI    = 3'd2,
		CMD_CIRCLE = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_READ   = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_DIAG = 2'd1,
		STAT_ROW  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] row;
		logic [5:0] col;
		logic [5:0] height;
		logic [6:0] width;
		logic [4:0] row_end;
		logic [5:0] col_end;
		logic [5:0] radius;
	} req_word_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [4:0]            row_index;
		logic [ROW_BITS_W-1:0] row_bits;
		logic                  last;
	} rsp_word_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ROW_ADDR_W-1:0] rd_addr;
		logic                  wr_en;
		logic [ROW_ADDR_W-1:0] wr_addr;
		logic                  clr;
	} canvas_req_t;

	function automatic logic [ROW_BITS_W-1:0] span_mask(logic signed [7:0] lo,
			logic signed [7:0] hi);
		logic [5:0]            l;
		logic [5:0]            h;
		logic [ROW_BITS_W-1:0] m;
		m = '0;
		l = '0;
		h = '0;
		if (!(hi < 8'sd0) && !(lo > 8'sd63) && !(lo > hi)) begin
			l = (lo < 8'sd0) ? 6'd0 : lo[5:0];
			h = (hi > 8'sd63) ? 6'd63 : hi[5:0];
			m = ({ROW_BITS_W{1'b1}} << l) & ({ROW_BITS_W{1'b1}} >> (6'd63 - h));
		end
		return m;
	endfunction

endpackage

FILE: rtl/bsr_canvas.sv
// ----------------------------------------------------------------------------
// bsr_canvas
// Pixel store: one row word per entry, registered read, per-row valid flags
// so that reset and clear blank the whole canvas at once.
// ----------------------------------------------------------------------------
module bsr_canvas #(
	parameter int CANVAS_ROWS = bsr_pkg::CANVAS_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsr_pkg::canvas_req_t                ctl,
	input  logic [bsr_pkg::ROW_BITS_W-1:0]      wr_data,
	output logic [bsr_pkg::ROW_BITS_W-1:0]      rd_data
);

	localparam int AW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

	logic [bsr_pkg::ROW_BITS_W-1:0] mem [CANVAS_ROWS];
	logic [CANVAS_ROWS-1:0]         vld_q;
	logic                           rd_vld_s1;
	logic [bsr_pkg::ROW_BITS_W-1:0] rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[ctl.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_s1 <= vld_q[ctl.rd_addr[AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr[AW-1:0]] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[ctl.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

FILE: rtl/bsr_row_unit.sv
// ----------------------------------------------------------------------------
// bsr_row_unit
// Shared row update: decides whether the current row is touched, forms the
// clipped column span and merges it into the old row word.
// ----------------------------------------------------------------------------
module bsr_row_unit #(
	parameter int CANVAS_COLS = bsr_pkg::CANVAS_COLS_DEF
) (
	input  bsr_pkg::req_word_t                  cmd,
	input  logic [bsr_pkg::ROW_ADDR_W-1:0]      row_idx,
	input  logic [5:0]                          circ_h,
	input  logic                                circ_ok,
	input  logic [bsr_pkg::ROW_BITS_W-1:0]      old_bits,
	output logic [bsr_pkg::ROW_BITS_W-1:0]      new_bits
);

	localparam logic [bsr_pkg::ROW_BITS_W-1:0] COL_MASK = (CANVAS_COLS >= 64) ?
		{bsr_pkg::ROW_BITS_W{1'b1}} :
		((bsr_pkg::ROW_BITS_W'(1) << CANVAS_COLS) - bsr_pkg::ROW_BITS_W'(1));

	logic [6:0]                     r7;
	logic [6:0]                     top7;
	logic [6:0]                     end7;
	logic                           in_band;
	logic signed [7:0]              lo;
	logic signed [7:0]              hi;
	logic                           act;
	logic                           erase;
	logic [5:0]                     tri_i;
	logic [bsr_pkg::ROW_BITS_W-1:0] mask;

	always_comb begin
		r7      = {1'b0, row_idx};
		top7    = {2'b00, cmd.row};
		end7    = top7 + {1'b0, cmd.height};
		in_band = (r7 >= top7) && (r7 < end7);
		tri_i   = row_idx - {1'b0, cmd.row};
		lo      = $signed({2'b00, cmd.col});
		hi      = lo;
		act     = 1'b0;
		erase   = 1'b0;
		unique case (cmd.cmd) inside
			bsr_pkg::CMD_FILL, bsr_pkg::CMD_ERASE: begin
				act   = in_band && (cmd.height != '0) && (cmd.width != '0);
				hi    = cmd.width[6] ? 8'sd63 : (lo + $signed({1'b0, cmd.width}) - 8'sd1);
				erase = (cmd.cmd == bsr_pkg::CMD_ERASE);
			end
			bsr_pkg::CMD_LINE: begin
				if (cmd.row == cmd.row_end) begin
					act = (r7 == top7);
					hi  = $signed({2'b00, cmd.col_end});
				end else if (cmd.col == cmd.col_end) begin
					act = (r7 >= top7) && (r7 <= {2'b00, cmd.row_end});
				end
			end
			bsr_pkg::CMD_TRI: begin
				act = in_band;
				hi  = lo + $signed({2'b00, tri_i});
			end
			bsr_pkg::CMD_CIRCLE: begin
				act = circ_ok;
				lo  = $signed({2'b00, cmd.col}) - $signed({2'b00, circ_h});
				hi  = $signed({2'b00, cmd.col}) + $signed({2'b00, circ_h});
			end
			default: begin
				act = 1'b0;
			end
		endcase
		mask     = act ? (bsr_pkg::span_mask(lo, hi) & COL_MASK) : '0;
		new_bits = erase ? (old_bits & ~mask) : (old_bits | mask);
	end

endmodule

FILE: rtl/bitmap_shape_rasterizer.sv
// ----------------------------------------------------------------------------
// bitmap_shape_rasterizer
// Fill, erase, line and triangle: one row updated a cycle, over every canvas row.
// Circle: per row a read, the 6-step square-root search on one squarer, a write.
// Read out: row by row through the canvas read port, held under stall.
// Clear, diagonal line: straight to the status word. Reset blanks the canvas at once.
// ----------------------------------------------------------------------------
module bitmap_shape_rasterizer #(
	parameter int CANVAS_ROWS = bsr_pkg::CANVAS_ROWS_DEF,
	parameter int CANVAS_COLS = bsr_pkg::CANVAS_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bsr_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bsr_pkg::rsp_word_t rsp
);

	localparam int AW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
	localparam logic [AW-1:0] LAST_ROW = AW'(CANVAS_ROWS - 1);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_WALK    = 8'b0000_0010,
		ST_CIRC_RD = 8'b0000_0100,
		ST_CIRC_SQ = 8'b0000_1000,
		ST_CIRC_WR = 8'b0001_0000,
		ST_OUT_RD  = 8'b0010_0000,
		ST_OUT_LD  = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	bsr_pkg::req_word_t              cmd_q;
	logic [AW-1:0]                   ptr_q;
	logic                            rd_done_q;
	logic                            wr_vld_s1;
	logic [AW-1:0]                   wr_row_s1;
	logic [11:0]                     rr_q;
	logic signed [12:0]              q_q;
	logic [5:0]                      h_q;
	logic [2:0]                      bit_q;
	logic [1:0]                      status_q;
	bsr_pkg::rsp_word_t              rsp_q;
	logic                            rsp_valid_q;

	logic [5:0]                      rowp;
	logic [5:0]                      rowc;
	logic [5:0]                      dr_abs;
	logic [5:0]                      trial;
	logic [5:0]                      sq_in;
	logic [11:0]                     sq;
	logic signed [12:0]              q_next;
	logic                            out_free;
	logic                            rsp_load;
	bsr_pkg::rsp_word_t              rsp_next;
	bsr_pkg::canvas_req_t            cv_ctl;
	logic [bsr_pkg::ROW_BITS_W-1:0]  rd_data;
	logic [bsr_pkg::ROW_BITS_W-1:0]  wr_data;
	logic                            accept;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		rowp   = 6'(ptr_q);
		rowc   = {1'b0, cmd_q.row};
		dr_abs = (rowp >= rowc) ? (rowp - rowc) : (rowc - rowp);
		trial  = h_q | (6'd1 << bit_q);
		unique case (state_q)
			ST_IDLE:    sq_in = req.radius;
			ST_CIRC_RD: sq_in = dr_abs;
			ST_CIRC_SQ: sq_in = trial;
			default:    sq_in = '0;
		endcase
		sq     = {6'd0, sq_in} * {6'd0, sq_in};
		q_next = $signed({1'b0, rr_q}) - $signed({1'b0, sq});
	end

	always_comb begin
		cv_ctl.rd_en   = ((state_q == ST_WALK) && !rd_done_q) ||
			(state_q == ST_CIRC_RD) || (state_q == ST_OUT_RD);
		cv_ctl.rd_addr = bsr_pkg::ROW_ADDR_W'(ptr_q);
		cv_ctl.wr_en   = ((state_q == ST_WALK) && wr_vld_s1) || (state_q == ST_CIRC_WR);
		cv_ctl.wr_addr = bsr_pkg::ROW_ADDR_W'(wr_row_s1);
		cv_ctl.clr     = accept && (req.cmd == bsr_pkg::CMD_CLEAR);
	end

	bsr_canvas #(
		.CANVAS_ROWS (CANVAS_ROWS)
	) u_canvas (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cv_ctl),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	bsr_row_unit #(
		.CANVAS_COLS (CANVAS_COLS)
	) u_row_unit (
		.cmd      (cmd_q),
		.row_idx  (bsr_pkg::ROW_ADDR_W'(wr_row_s1)),
		.circ_h   (h_q),
		.circ_ok  (!q_q[12]),
		.old_bits (rd_data),
		.new_bits (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= '0;
			ptr_q     <= '0;
			rd_done_q <= 1'b0;
			wr_vld_s1 <= 1'b0;
			wr_row_s1 <= '0;
			rr_q      <= '0;
			q_q       <= '0;
			h_q       <= '0;
			bit_q     <= '0;
			status_q  <= bsr_pkg::STAT_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q     <= req;
						ptr_q     <= '0;
						rd_done_q <= 1'b0;
						wr_vld_s1 <= 1'b0;
						rr_q      <= sq;
						status_q  <= bsr_pkg::STAT_DONE;
						unique case (req.cmd) inside
							bsr_pkg::CMD_FILL, bsr_pkg::CMD_TRI, bsr_pkg::CMD_ERASE: begin
								state_q <= ST_WALK;
							end
							bsr_pkg::CMD_LINE: begin
								if ((req.row == req.row_end) || (req.col == req.col_end)) begin
									state_q <= ST_WALK;
								end else begin
									status_q <= bsr_pkg::STAT_DIAG;
									state_q  <= ST_RESP;
								end
							end
							bsr_pkg::CMD_CIRCLE: state_q <= ST_CIRC_RD;
							bsr_pkg::CMD_READ:   state_q <= ST_OUT_RD;
							default:             state_q <= ST_RESP;
						endcase
					end
				end
				ST_WALK: begin
					if (!rd_done_q) begin
						wr_vld_s1 <= 1'b1;
						wr_row_s1 <= ptr_q;
						if (ptr_q == LAST_ROW) begin
							rd_done_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else begin
						wr_vld_s1 <= 1'b0;
						state_q   <= ST_RESP;
					end
				end
				ST_CIRC_RD: begin
					wr_row_s1 <= ptr_q;
					q_q       <= q_next;
					h_q       <= '0;
					bit_q     <= 3'd5;
					state_q   <= q_next[12] ? ST_CIRC_WR : ST_CIRC_SQ;
				end
				ST_CIRC_SQ: begin
					if (sq <= q_q[11:0]) begin
						h_q <= trial;
					end
					if (bit_q == '0) begin
						state_q <= ST_CIRC_WR;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_CIRC_WR: begin
					if (ptr_q == LAST_ROW) begin
						state_q <= ST_RESP;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_CIRC_RD;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (out_free) begin
						if (ptr_q == LAST_ROW) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp_load = out_free && ((state_q == ST_OUT_LD) || (state_q == ST_RESP));
		if (state_q == ST_OUT_LD) begin
			rsp_next.status    = bsr_pkg::STAT_ROW;
			rsp_next.row_index = 5'(ptr_q);
			rsp_next.row_bits  = rd_data;
			rsp_next.last      = (ptr_q == LAST_ROW);
		end else begin
			rsp_next.status    = status_q;
			rsp_next.row_index = '0;
			rsp_next.row_bits  = '0;
			rsp_next.last      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_next;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/bsr_checker.sv
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks of the bitmap shape rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module bsr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input bsr_pkg::rsp_word_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command word taken while a command is in progress");

	a_status_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != bsr_pkg::STAT_ROW) |->
			rsp.last && (rsp.row_bits == '0) && (rsp.row_index == '0))
		else $error("status word carries row data or is not marked last");

endmodule

bind bitmap_shape_rasterizer bsr_checker u_bsr_checker (.*);
